/* hw/rtl/rpc_pkg.sv */
// Shared types and constants for the rectangular/polar converter.
// Used by rpc_prep, rpc_cordic, the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package rpc_pkg;

    // Angle field widths: output angle, CORDIC angle accumulator and turn remainder
    localparam int ANG_W  = 20;
    localparam int Z_W    = 21;
    localparam int TURN_W = 17;

    // Form codes
    localparam logic [1:0] FORM_RECT  = 2'd0;
    localparam logic [1:0] FORM_POLAR = 2'd1;

    // Angle constants, signed Q4.16 radians
    localparam logic signed [Z_W-1:0] PI_Q16      = 21'sd205887;
    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [Z_W-1:0] TWO_PI_Q16  = 21'sd411775;

    // 1/K of the CORDIC, Q16
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    // One full turn in 1/256 degree
    localparam logic [TURN_W-1:0] FULL_TURN = 17'd92160;

    // Whole part of pi*2^32/180; the fraction is 105/180 = 7/12
    localparam logic [26:0] RAD_PER_UNIT = 27'd74961320;

    // ceil(2^19/3) for an exact divide by three on 18-bit values
    localparam logic [17:0] THIRD_RECIP = 18'd174763;

    // Control group that travels with an item through the CORDIC
    typedef struct packed {
        logic [1:0]       form;
        logic             neg;
        logic             y_zero;
        logic             x_neg;
        logic [ANG_W-1:0] ang;
    } ctl_t;

    // Arctangent of 2^-i, Q16 radians
    function automatic logic [Z_W-1:0] atan_q16(input int unsigned idx);
        logic [Z_W-1:0] val;
        case (idx)
            0:       val = 21'd51472;
            1:       val = 21'd30386;
            2:       val = 21'd16055;
            3:       val = 21'd8150;
            4:       val = 21'd4091;
            5:       val = 21'd2047;
            6:       val = 21'd1024;
            7:       val = 21'd512;
            8:       val = 21'd256;
            9:       val = 21'd128;
            10:      val = 21'd64;
            11:      val = 21'd32;
            12:      val = 21'd16;
            13:      val = 21'd8;
            14:      val = 21'd4;
            15:      val = 21'd2;
            16:      val = 21'd1;
            default: val = 21'd0;
        endcase
        return val;
    endfunction

endpackage

/* hw/rtl/rpc_delay.sv */
// Fixed-length delay line with a valid bit, used to align the two paths.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module rpc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    generate
        if (DEPTH == 0) begin : g_none
            assign out_valid = in_valid;
            assign out_data  = in_data;
        end else begin : g_line
            logic [DEPTH-1:0] valid_reg;
            logic [WIDTH-1:0] data_reg [DEPTH];

            // valid bits, cleared at reset
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg <= '0;
                end
                else
                begin
                    valid_reg[0] <= in_valid;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        valid_reg[i] <= valid_reg[i-1];
                    end
                end
            end

            // payload taps
            always_ff @(posedge clk)
            begin
                data_reg[0] <= in_data;
                for (int i = 1; i < DEPTH; i++)
                begin
                    data_reg[i] <= data_reg[i-1];
                end
            end

            assign out_valid = valid_reg[DEPTH-1];
            assign out_data  = data_reg[DEPTH-1];
        end
    endgenerate

endmodule

/* hw/rtl/rpc_sqrt.sv */
// Pipelined rounded magnitude sqrt(x^2+y^2), one root bit per stage.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module rpc_sqrt #(
    parameter int CW = 24
) (
    input  logic                 clk,
    input  logic signed [CW-1:0] x,
    input  logic signed [CW-1:0] y,
    output logic        [CW-1:0] mag
);

    localparam int SW = 2 * CW;
    localparam int RW = CW + 2;

    logic signed [SW-1:0] x_ext, y_ext, xx_next, yy_next;
    logic        [SW-1:0] xx_reg, yy_reg;
    logic        [SW-1:0] rad_reg  [CW+1];
    logic        [RW-1:0] rem_reg  [CW+1];
    logic        [CW-1:0] root_reg [CW+1];
    logic        [CW:0]   rnd;
    logic        [CW:0]   lim;
    logic        [CW-1:0] mag_reg;

    // squares
    assign x_ext   = {{CW{x[CW-1]}}, x};
    assign y_ext   = {{CW{y[CW-1]}}, y};
    assign xx_next = x_ext * x_ext;
    assign yy_next = y_ext * y_ext;

    always_ff @(posedge clk)
    begin
        xx_reg      <= xx_next;
        yy_reg      <= yy_next;
        rad_reg[0]  <= xx_reg + yy_reg;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
    end

    // digit-by-digit root, one bit per stage
    for (genvar k = 0; k < CW; k++) begin : g_root
        logic [RW-1:0] rem_sh, trial;
        logic          fits;

        assign rem_sh = {rem_reg[k][CW-1:0], rad_reg[k][SW-1:SW-2]};
        assign trial  = {root_reg[k], 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            rad_reg[k+1]  <= {rad_reg[k][SW-3:0], 2'b00};
            rem_reg[k+1]  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg[k+1] <= {root_reg[k][CW-2:0], fits};
        end
    end

    // round to nearest, saturate at the largest positive coordinate
    assign rnd = {1'b0, root_reg[CW]}
               + (CW+1)'(rem_reg[CW] > RW'(root_reg[CW]));
    assign lim = (CW+1)'((1 << (CW - 1)) - 1);

    always_ff @(posedge clk)
    begin
        mag_reg <= (rnd > lim) ? lim[CW-1:0] : rnd[CW-1:0];
    end

    assign mag = mag_reg;

endmodule

/* hw/rtl/rpc_prep.sv */
// Front end: degree-to-radian reduction for polar items and CORDIC start vector.
// Uses rpc_pkg (constants, ctl_t); seven register stages.
`timescale 1ns / 1ps

module rpc_prep #(
    parameter int CW = 24,
    parameter int W  = 42
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic signed [CW-1:0]        a,
    input  logic signed [CW-1:0]        b,
    input  logic [1:0]                  form,
    output logic                        out_valid,
    output rpc_pkg::ctl_t               out_ctl,
    output logic signed [CW-1:0]        out_a,
    output logic signed [CW-1:0]        out_b,
    output logic signed [W-1:0]         out_cx,
    output logic signed [W-1:0]         out_cy,
    output logic signed [rpc_pkg::Z_W-1:0] out_z
);

    localparam int    UW     = CW + 2;
    localparam int    TW     = UW - 11;
    localparam int    SH     = CW + 7;
    localparam int    KW     = SH - 4;
    localparam int    QW     = TW + KW - SH;
    localparam int    SBW    = 2 + 2 * CW;
    localparam int    TN     = rpc_pkg::TURN_W;
    localparam int    ZW     = rpc_pkg::Z_W;
    localparam int    AW     = rpc_pkg::ANG_W;
    localparam longint HALF_RANGE = longint'(1) << (CW - 1);
    localparam longint OFF   = ((HALF_RANGE + 92159) / 92160) * 92160;
    localparam logic [UW-1:0] OFF_U = UW'(OFF);
    localparam logic [KW-1:0] RECIP = KW'(((longint'(1) << SH) + 44) / 45);
    localparam logic [43:0] RAD_PER_UNIT_EXT = 44'(rpc_pkg::RAD_PER_UNIT);

    // side data {form, a, b} and valid travel with each stage
    logic [SBW-1:0] side_reg  [6];
    logic [5:0]     valid_reg;

    logic [UW-1:0]    u_next, u1_reg, u2_reg;
    logic [TW+KW-1:0] q_prod;
    logic [QW-1:0]    q_reg;
    logic [QW+TN-1:0] qt_prod;
    logic [UW-1:0]    diff;
    logic [TN-1:0]    r_reg;
    logic [43:0]      hi_next, hi4_reg, hi5_reg;
    logic [19:0]      r7;
    logic [17:0]      w_reg;
    logic [35:0]      f_prod;
    logic [16:0]      f_reg;
    logic [44:0]      ang_sum;
    logic [AW-1:0]    ang_reg;

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
            out_valid <= valid_reg[5];
        end
    end

    // side data pipeline
    always_ff @(posedge clk)
    begin
        side_reg[0] <= {form, a, b};
        for (int i = 1; i < 6; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // stage 1: offset angle to non-negative
    assign u_next = {{(UW-CW){b[CW-1]}}, b} + OFF_U;

    // stage 2: quotient by a full turn, as (u/2048)/45 by reciprocal
    assign q_prod = u1_reg[UW-1:11] * RECIP;

    // stage 3: remainder
    assign qt_prod = q_reg * rpc_pkg::FULL_TURN;
    assign diff    = u2_reg - UW'(qt_prod);

    // stage 4: whole part and the 7/12 fraction numerator
    assign hi_next = r_reg * RAD_PER_UNIT_EXT;
    assign r7      = r_reg * 20'd7;

    // stage 5: divide by three
    assign f_prod = w_reg * rpc_pkg::THIRD_RECIP;

    // stage 6: round to Q16 radians
    assign ang_sum = {1'b0, hi5_reg} + 45'(f_reg) + 45'(1 << 23);

    always_ff @(posedge clk)
    begin
        u1_reg  <= u_next;
        q_reg   <= q_prod[TW+KW-1:SH];
        u2_reg  <= u1_reg;
        r_reg   <= diff[TN-1:0];
        hi4_reg <= hi_next;
        w_reg   <= r7[19:2];
        hi5_reg <= hi4_reg;
        f_reg   <= f_prod[35:19];
        ang_reg <= ang_sum[AW+23:24];
    end

    // stage 7: start vector for either CORDIC mode
    logic [1:0]           f7;
    logic signed [CW-1:0] a7, b7;
    logic signed [W-1:0]  a_ext, a_sh, b_sh, cx_next, cy_next;
    logic signed [ZW-1:0] z_next;
    logic                 neg_next;

    assign {f7, a7, b7} = side_reg[5];
    assign a_ext = {{(W-CW){a7[CW-1]}}, a7};
    assign a_sh  = {{(W-CW-16){a7[CW-1]}}, a7, 16'b0};
    assign b_sh  = {{(W-CW-16){b7[CW-1]}}, b7, 16'b0};

    always_comb
    begin
        z_next   = '0;
        neg_next = 1'b0;
        cx_next  = a_sh;
        cy_next  = b_sh;
        if (f7 == rpc_pkg::FORM_POLAR)
        begin
            z_next  = $signed(ZW'(ang_reg));
            if (z_next > rpc_pkg::PI_Q16)
            begin
                z_next = z_next - rpc_pkg::TWO_PI_Q16;
            end
            if (z_next > rpc_pkg::HALF_PI_Q16)
            begin
                z_next   = z_next - rpc_pkg::PI_Q16;
                neg_next = 1'b1;
            end
            else if (z_next < -rpc_pkg::HALF_PI_Q16)
            begin
                z_next   = z_next + rpc_pkg::PI_Q16;
                neg_next = 1'b1;
            end
            cx_next = a_ext * $signed(W'(rpc_pkg::INV_GAIN_Q16));
            cy_next = '0;
        end
        else if (a7[CW-1])
        begin
            // left half plane: flip and start from +-pi
            z_next  = b7[CW-1] ? -rpc_pkg::PI_Q16 : rpc_pkg::PI_Q16;
            cx_next = -a_sh;
            cy_next = -b_sh;
        end
    end

    always_ff @(posedge clk)
    begin
        out_ctl.form   <= f7;
        out_ctl.neg    <= neg_next;
        out_ctl.y_zero <= (b7 == '0);
        out_ctl.x_neg  <= a7[CW-1];
        out_ctl.ang    <= ang_reg;
        out_a          <= a7;
        out_b          <= b7;
        out_cx         <= cx_next;
        out_cy         <= cy_next;
        out_z          <= z_next;
    end

endmodule

/* hw/rtl/rpc_cordic.sv */
// Unrolled CORDIC, one micro-rotation per register stage.
// Vectoring for rectangular items, rotation for polar ones; uses rpc_pkg.
`timescale 1ns / 1ps

module rpc_cordic #(
    parameter int CW     = 24,
    parameter int W      = 42,
    parameter int STAGES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  rpc_pkg::ctl_t                  in_ctl,
    input  logic signed [CW-1:0]           in_a,
    input  logic signed [CW-1:0]           in_b,
    input  logic signed [W-1:0]            in_cx,
    input  logic signed [W-1:0]            in_cy,
    input  logic signed [rpc_pkg::Z_W-1:0] in_z,
    output logic                           out_valid,
    output rpc_pkg::ctl_t                  out_ctl,
    output logic signed [CW-1:0]           out_a,
    output logic signed [CW-1:0]           out_b,
    output logic signed [W-1:0]            out_cx,
    output logic signed [W-1:0]            out_cy,
    output logic signed [rpc_pkg::Z_W-1:0] out_z
);

    localparam int ZW = rpc_pkg::Z_W;

    wire                 v_in   [STAGES];
    wire rpc_pkg::ctl_t  ctl_in [STAGES];
    wire signed [CW-1:0] a_in   [STAGES];
    wire signed [CW-1:0] b_in   [STAGES];
    wire signed [W-1:0]  cx_in  [STAGES];
    wire signed [W-1:0]  cy_in  [STAGES];
    wire signed [ZW-1:0] z_in   [STAGES];

    logic                 v_reg   [STAGES];
    rpc_pkg::ctl_t        ctl_reg [STAGES];
    logic signed [CW-1:0] a_reg   [STAGES];
    logic signed [CW-1:0] b_reg   [STAGES];
    logic signed [W-1:0]  cx_reg  [STAGES];
    logic signed [W-1:0]  cy_reg  [STAGES];
    logic signed [ZW-1:0] z_reg   [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                up;
        logic signed [W-1:0]  cx_next, cy_next;
        logic signed [ZW-1:0] z_next, step;

        // stage input
        if (k == 0) begin : g_first
            assign v_in[k]   = in_valid;
            assign ctl_in[k] = in_ctl;
            assign a_in[k]   = in_a;
            assign b_in[k]   = in_b;
            assign cx_in[k]  = in_cx;
            assign cy_in[k]  = in_cy;
            assign z_in[k]   = in_z;
        end else begin : g_next
            assign v_in[k]   = v_reg[k-1];
            assign ctl_in[k] = ctl_reg[k-1];
            assign a_in[k]   = a_reg[k-1];
            assign b_in[k]   = b_reg[k-1];
            assign cx_in[k]  = cx_reg[k-1];
            assign cy_in[k]  = cy_reg[k-1];
            assign z_in[k]   = z_reg[k-1];
        end

        // direction: drive y to zero, or drive z to zero
        assign step = $signed(rpc_pkg::atan_q16(k));
        assign up   = (ctl_in[k].form == rpc_pkg::FORM_RECT) ? cy_in[k][W-1]
                                                            : !z_in[k][ZW-1];

        always_comb
        begin
            if (up)
            begin
                cx_next = cx_in[k] - (cy_in[k] >>> k);
                cy_next = cy_in[k] + (cx_in[k] >>> k);
                z_next  = z_in[k] - step;
            end
            else
            begin
                cx_next = cx_in[k] + (cy_in[k] >>> k);
                cy_next = cy_in[k] - (cx_in[k] >>> k);
                z_next  = z_in[k] + step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in[k];
            end
        end

        always_ff @(posedge clk)
        begin
            ctl_reg[k] <= ctl_in[k];
            a_reg[k]   <= a_in[k];
            b_reg[k]   <= b_in[k];
            cx_reg[k]  <= cx_next;
            cy_reg[k]  <= cy_next;
            z_reg[k]   <= z_next;
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_ctl   = ctl_reg[STAGES-1];
    assign out_a     = a_reg[STAGES-1];
    assign out_b     = b_reg[STAGES-1];
    assign out_cx    = cx_reg[STAGES-1];
    assign out_cy    = cy_reg[STAGES-1];
    assign out_z     = z_reg[STAGES-1];

endmodule

/* hw/rtl/rect_polar_converter.sv */
// Top level of the rectangular/polar converter.
// Uses rpc_pkg, rpc_delay, rpc_sqrt, rpc_prep and rpc_cordic.
//
// Usage:
//   Drive first_value, second_value and form and raise start; the item is
//   taken at any rising edge with start high, and busy is always low, so a
//   new item may be given every cycle.
//   form 0: inputs are x, y (Q15.8). Outputs x, y, rounded magnitude and
//   atan2 angle in Q2.16 radians (0 for the zero vector).
//   form 1: inputs are magnitude and angle in 1/256 degree. Outputs x, y
//   from a rotation CORDIC, the magnitude passed through and the angle
//   reduced to [0, 2*pi) in Q3.16 radians. Other codes give zeros and
//   bad_form.
//   Each result is shown with done high for exactly one cycle; the
//   receiver cannot stall, and results leave in the order items came in.
// Pipeline:
//   An item passes the input register, a delay line, angle reduction and
//   the CORDIC chain, or the magnitude root (one bit per stage), then the
//   output register; the delay lines align the two paths. Throughput: one
//   item per cycle.
// Reset clears all valid bits; items in flight are dropped.
`timescale 1ns / 1ps

module rect_polar_converter #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_WIDTH-1:0]     first_value,
    input  logic signed [COORD_WIDTH-1:0]     second_value,
    input  logic [1:0]                        form,
    output logic                              done,
    output logic signed [COORD_WIDTH-1:0]     coord_x,
    output logic signed [COORD_WIDTH-1:0]     coord_y,
    output logic signed [COORD_WIDTH-1:0]     magnitude,
    output logic signed [rpc_pkg::ANG_W-1:0]  angle_rad,
    output logic                              mode_out,
    output logic                              bad_form
);

    localparam int CW    = COORD_WIDTH;
    localparam int W     = CW + 18;
    localparam int ZW    = rpc_pkg::Z_W;
    localparam int AW    = rpc_pkg::ANG_W;
    localparam int LAT_C = CORDIC_STAGES + 7;
    localparam int LAT_S = CW + 3;
    localparam int LAT_M = (LAT_C > LAT_S) ? LAT_C : LAT_S;
    localparam int RW    = CW + 3;

    // input register
    logic                 in_v_reg;
    logic signed [CW-1:0] a_in_reg, b_in_reg;
    logic [1:0]           form_in_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        a_in_reg    <= first_value;
        b_in_reg    <= second_value;
        form_in_reg <= form;
    end

    // align the angle path and the magnitude path
    logic                 c_v;
    logic [2*CW+1:0]      c_data;
    logic                 s_v;
    logic [2*CW-1:0]      s_data;

    rpc_delay #(.WIDTH(2*CW+2), .DEPTH(LAT_M-LAT_C)) u_dly_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_v_reg),
        .in_data  ({form_in_reg, a_in_reg, b_in_reg}),
        .out_valid(c_v),
        .out_data (c_data)
    );

    rpc_delay #(.WIDTH(2*CW), .DEPTH(LAT_M-LAT_S)) u_dly_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_v_reg),
        .in_data  ({a_in_reg, b_in_reg}),
        .out_valid(s_v),
        .out_data (s_data)
    );

    // magnitude
    logic [CW-1:0] sq_mag;

    rpc_sqrt #(.CW(CW)) u_sqrt (
        .clk(clk),
        .x  ($signed(s_data[2*CW-1:CW])),
        .y  ($signed(s_data[CW-1:0])),
        .mag(sq_mag)
    );

    // angle reduction and CORDIC
    logic                 p_v;
    rpc_pkg::ctl_t        p_ctl;
    logic signed [CW-1:0] p_a, p_b;
    logic signed [W-1:0]  p_cx, p_cy;
    logic signed [ZW-1:0] p_z;

    rpc_prep #(.CW(CW), .W(W)) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_v),
        .a        ($signed(c_data[2*CW-1:CW])),
        .b        ($signed(c_data[CW-1:0])),
        .form     (c_data[2*CW+1:2*CW]),
        .out_valid(p_v),
        .out_ctl  (p_ctl),
        .out_a    (p_a),
        .out_b    (p_b),
        .out_cx   (p_cx),
        .out_cy   (p_cy),
        .out_z    (p_z)
    );

    logic                 k_v;
    rpc_pkg::ctl_t        k_ctl;
    logic signed [CW-1:0] k_a, k_b;
    logic signed [W-1:0]  k_cx, k_cy;
    logic signed [ZW-1:0] k_z;

    rpc_cordic #(.CW(CW), .W(W), .STAGES(CORDIC_STAGES)) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p_v),
        .in_ctl   (p_ctl),
        .in_a     (p_a),
        .in_b     (p_b),
        .in_cx    (p_cx),
        .in_cy    (p_cy),
        .in_z     (p_z),
        .out_valid(k_v),
        .out_ctl  (k_ctl),
        .out_a    (k_a),
        .out_b    (k_b),
        .out_cx   (k_cx),
        .out_cy   (k_cy),
        .out_z    (k_z)
    );

    // polar result: round half up to Q8, undo the fold, saturate
    localparam logic signed [RW-1:0] MAX_C = RW'((longint'(1) << (CW - 1)) - 1);
    localparam logic signed [RW-1:0] MIN_C = -MAX_C - RW'(1);

    logic signed [W-1:0]  xr_sum, yr_sum;
    logic signed [RW-1:0] xr, yr, xs, ys;
    logic signed [ZW-1:0] z_clamp;

    assign xr_sum = k_cx + $signed(W'(32768));
    assign yr_sum = k_cy + $signed(W'(32768));
    assign xr = k_ctl.neg ? -{xr_sum[W-1], xr_sum[W-1:16]} : {xr_sum[W-1], xr_sum[W-1:16]};
    assign yr = k_ctl.neg ? -{yr_sum[W-1], yr_sum[W-1:16]} : {yr_sum[W-1], yr_sum[W-1:16]};
    assign xs = (xr > MAX_C) ? MAX_C : ((xr < MIN_C) ? MIN_C : xr);
    assign ys = (yr > MAX_C) ? MAX_C : ((yr < MIN_C) ? MIN_C : yr);

    // rectangular angle: clamp to +-pi, axis cases fixed
    always_comb
    begin
        if (k_ctl.y_zero)
        begin
            z_clamp = k_ctl.x_neg ? rpc_pkg::PI_Q16 : '0;
        end
        else if (k_z > rpc_pkg::PI_Q16)
        begin
            z_clamp = rpc_pkg::PI_Q16;
        end
        else if (k_z < -rpc_pkg::PI_Q16)
        begin
            z_clamp = -rpc_pkg::PI_Q16;
        end
        else
        begin
            z_clamp = k_z;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= k_v;
        end
    end

    always_ff @(posedge clk)
    begin
        case (k_ctl.form)
            rpc_pkg::FORM_RECT:
            begin
                coord_x   <= k_a;
                coord_y   <= k_b;
                magnitude <= $signed(sq_mag);
                angle_rad <= z_clamp[AW-1:0];
                mode_out  <= 1'b0;
                bad_form  <= 1'b0;
            end
            rpc_pkg::FORM_POLAR:
            begin
                coord_x   <= xs[CW-1:0];
                coord_y   <= ys[CW-1:0];
                magnitude <= k_a;
                angle_rad <= k_ctl.ang;
                mode_out  <= 1'b1;
                bad_form  <= 1'b0;
            end
            default:
            begin
                coord_x   <= '0;
                coord_y   <= '0;
                magnitude <= '0;
                angle_rad <= '0;
                mode_out  <= 1'b0;
                bad_form  <= 1'b1;
            end
        endcase
    end

    localparam int LAT_CHK = LAT_M + 2;

`ifndef SYNTHESIS
    // every result traces back to an item taken a fixed time before
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT_CHK))
        else $error("result without a matching item");

    // the root leaving the magnitude path belongs to the item leaving the CORDIC
    a_mag_align: assert property (@(posedge clk) disable iff (!rst_n)
        k_v |-> $past(s_v, LAT_S))
        else $error("magnitude path out of step");

    // an invalid form gives all-zero fields
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_form |-> coord_x == '0 && coord_y == '0 && magnitude == '0
                             && angle_rad == '0 && !mode_out)
        else $error("invalid form result not cleared");

    // rectangular angle stays within +-pi
    a_rect_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !bad_form && !mode_out |->
            $signed(angle_rad) <= 20'sd205887 && $signed(angle_rad) >= -20'sd205887)
        else $error("rectangular angle out of range");

    // polar magnitude is the item's first value
    a_polar_mag: assert property (@(posedge clk) disable iff (!rst_n)
        done && mode_out |-> magnitude == $past(first_value, LAT_CHK))
        else $error("polar magnitude not passed through");
`endif

endmodule

/* dv/rect_polar_converter_tb.sv */
// Self-checking testbench for rect_polar_converter: directed table, then random items.
// Depends on rpc_pkg and the rect_polar_converter RTL.
`timescale 1ns / 1ps

module rect_polar_converter_tb;

    localparam int CW        = 24;
    localparam int AW        = rpc_pkg::ANG_W;
    localparam int STAGES    = 16;
    localparam int LATENCY   = 28;
    localparam int N_RANDOM  = 1200;
    localparam int CYCLE_CAP = 200000;
    localparam logic [1:0] FORM_BAD2 = 2'd2;
    localparam logic [1:0] FORM_BAD3 = 2'd3;
    localparam longint PI_L     = 205887;
    localparam longint HPI_L    = 102944;
    localparam longint TPI_L    = 411775;
    localparam longint PI32_L   = 64'd13493037705;
    localparam longint TURN_L   = 92160;
    localparam longint IGAIN_L  = 39797;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] mag;
        logic signed [AW-1:0] ang;
        logic mode;
        logic bad;
    } conv_t;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic [1:0] f;
        bit has_exp;
        conv_t exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [CW-1:0] first_value = '0;
    logic signed [CW-1:0] second_value = '0;
    logic [1:0] form = '0;
    logic busy, done, mode_out, bad_form;
    logic signed [CW-1:0] coord_x, coord_y, magnitude;
    logic signed [AW-1:0] angle_rad;

    conv_t pending_q[$];
    int errors = 0;
    int cycles = 0;

    always #5 clk = ~clk;

    rect_polar_converter u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_value(first_value), .second_value(second_value), .form(form),
        .done(done), .coord_x(coord_x), .coord_y(coord_y), .magnitude(magnitude),
        .angle_rad(angle_rad), .mode_out(mode_out), .bad_form(bad_form)
    );

    // Arctangent table, Q16
    function automatic longint atan_tab(int i);
        longint t[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2, 1};
        return (i < 17) ? t[i] : 0;
    endfunction

    function automatic longint sat_c(longint v);
        longint hi;
        hi = (longint'(1) << (CW - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint root_round(longint s);
        longint r, lo, hi, mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= s) lo = mid; else hi = mid - 1;
        end
        r = lo;
        if (s - r * r > r) r = r + 1;
        return r;
    endfunction

    function automatic longint vec_angle(longint x, longint y);
        longint z, cx, cy, nx, ny;
        z = 0;
        if (y == 0) return (x >= 0) ? 0 : PI_L;
        cx = x * 65536;
        cy = y * 65536;
        if (x < 0) begin
            z = (y >= 0) ? PI_L : -PI_L;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < STAGES; i++) begin
            if (cy < 0) begin
                nx = cx - (cy >>> i); ny = cy + (cx >>> i); z -= atan_tab(i);
            end else begin
                nx = cx + (cy >>> i); ny = cy - (cx >>> i); z += atan_tab(i);
            end
            cx = nx;
            cy = ny;
        end
        if (z > PI_L) z = PI_L;
        if (z < -PI_L) z = -PI_L;
        return z;
    endfunction

    // Expected outputs of one conversion
    function automatic conv_t convert(longint a, longint b, logic [1:0] f);
        conv_t o;
        longint z, cx, cy, nx, ny, r;
        bit flip;
        o = '0;
        if (f == rpc_pkg::FORM_RECT) begin
            o.x = CW'(a);
            o.y = CW'(b);
            o.mag = CW'(sat_c(root_round(a * a + b * b)));
            o.ang = AW'(vec_angle(a, b));
        end else if (f == rpc_pkg::FORM_POLAR) begin
            r = b % TURN_L;
            if (r < 0) r += TURN_L;
            z = (((r * PI32_L) / 180) + (longint'(1) << 23)) >>> 24;
            o.ang = AW'(z);
            o.mag = CW'(a);
            o.mode = 1'b1;
            flip = 0;
            if (z > PI_L) z -= TPI_L;
            if (z > HPI_L) begin z -= PI_L; flip = 1; end
            else if (z < -HPI_L) begin z += PI_L; flip = 1; end
            cx = a * IGAIN_L;
            cy = 0;
            for (int i = 0; i < STAGES; i++) begin
                if (z >= 0) begin
                    nx = cx - (cy >>> i); ny = cy + (cx >>> i); z -= atan_tab(i);
                end else begin
                    nx = cx + (cy >>> i); ny = cy - (cx >>> i); z += atan_tab(i);
                end
                cx = nx;
                cy = ny;
            end
            cx = (cx + 32768) >>> 16;
            cy = (cy + 32768) >>> 16;
            if (flip) begin cx = -cx; cy = -cy; end
            o.x = CW'(sat_c(cx));
            o.y = CW'(sat_c(cy));
        end else begin
            o.bad = 1'b1;
        end
        return o;
    endfunction

    // Result checker: every done strobe against the oldest expected item
    always @(posedge clk) begin
        conv_t got, want;
        if (rst_n) begin
            cycles <= cycles + 1;
            if (done) begin
                got = '{coord_x, coord_y, magnitude, angle_rad, mode_out, bad_form};
                if (pending_q.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10) $display("unexpected result %h", got);
                end else begin
                    want = pending_q.pop_front();
                    if (got !== want) begin
                        errors = errors + 1;
                        if (errors <= 10) begin
                            $display("mismatch: exp x=%0d y=%0d m=%0d a=%0d md=%0b b=%0b",
                                want.x, want.y, want.mag, want.ang, want.mode, want.bad);
                            $display("          got x=%0d y=%0d m=%0d a=%0d md=%0b b=%0b",
                                got.x, got.y, got.mag, got.ang, got.mode, got.bad);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one item and wait for its acceptance
    task automatic send_item(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                             logic [1:0] f, bit has_exp, conv_t exp, bit idle_ok);
        conv_t pred;
        while (idle_ok && $urandom_range(99) < 26) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        first_value <= a;
        second_value <= b;
        form <= f;
        @(posedge clk);
        while (busy) @(posedge clk);
        pred = convert(a, b, f);
        pending_q.push_back(has_exp ? exp : pred);
    endtask

    function automatic logic signed [CW-1:0] rnd_coord();
        case ($urandom_range(3))
            0: return CW'($urandom_range(511) - 256);
            1: return CW'($urandom_range(65535) - 32768);
            default: return CW'($urandom);
        endcase
    endfunction

    initial begin
        row_t dir[$];
        row_t rw;
        conv_t e;
        int drain;
        logic [1:0] f;
        // Directed table; expected values typed in only where obvious
        e = '0;
        rw = '{0, 0, rpc_pkg::FORM_RECT, 1, e};               dir.push_back(rw);
        e = '0; e.x = CW'(256); e.mag = CW'(256);
        rw = '{256, 0, rpc_pkg::FORM_RECT, 1, e};             dir.push_back(rw);
        e = '0; e.x = CW'(-256); e.mag = CW'(256); e.ang = AW'(rpc_pkg::PI_Q16);
        rw = '{-256, 0, rpc_pkg::FORM_RECT, 1, e};            dir.push_back(rw);
        e = '0; e.bad = 1;
        rw = '{1234, -99, FORM_BAD2, 1, e};                   dir.push_back(rw);
        rw = '{-8388608, 8388607, FORM_BAD3, 1, e};           dir.push_back(rw);
        e = '0;
        rw = '{0, 12345, rpc_pkg::FORM_POLAR, 0, e};          dir.push_back(rw);
        rw = '{8388607, 8388607, rpc_pkg::FORM_RECT, 0, e};   dir.push_back(rw);
        rw = '{-8388608, -8388608, rpc_pkg::FORM_RECT, 0, e}; dir.push_back(rw);
        rw = '{-8388608, 0, rpc_pkg::FORM_RECT, 0, e};        dir.push_back(rw);
        rw = '{0, -256, rpc_pkg::FORM_RECT, 0, e};            dir.push_back(rw);
        rw = '{0, 256, rpc_pkg::FORM_RECT, 0, e};             dir.push_back(rw);
        rw = '{-256, -1, rpc_pkg::FORM_RECT, 0, e};           dir.push_back(rw);
        rw = '{-256, 1, rpc_pkg::FORM_RECT, 0, e};            dir.push_back(rw);
        rw = '{256, 0, rpc_pkg::FORM_POLAR, 0, e};            dir.push_back(rw);
        rw = '{256, 11520, rpc_pkg::FORM_POLAR, 0, e};        dir.push_back(rw);
        rw = '{256, 92160, rpc_pkg::FORM_POLAR, 0, e};        dir.push_back(rw);
        rw = '{256, -11520, rpc_pkg::FORM_POLAR, 0, e};       dir.push_back(rw);
        rw = '{256, 46080, rpc_pkg::FORM_POLAR, 0, e};        dir.push_back(rw);
        rw = '{256, 92159, rpc_pkg::FORM_POLAR, 0, e};        dir.push_back(rw);
        rw = '{-256, 23040, rpc_pkg::FORM_POLAR, 0, e};       dir.push_back(rw);
        rw = '{8388607, 8388607, rpc_pkg::FORM_POLAR, 0, e};  dir.push_back(rw);
        rw = '{-8388608, -8388608, rpc_pkg::FORM_POLAR, 0, e}; dir.push_back(rw);
        rw = '{8388607, 11520, rpc_pkg::FORM_POLAR, 0, e};    dir.push_back(rw);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
            send_item(dir[i].a, dir[i].b, dir[i].f, dir[i].has_exp, dir[i].exp, 0);

        // Random part; the middle stretch runs without idle cycles
        e = '0;
        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(9))
                0:       f = ($urandom_range(1)) ? FORM_BAD2 : FORM_BAD3;
                1, 2, 3, 4: f = rpc_pkg::FORM_RECT;
                default: f = rpc_pkg::FORM_POLAR;
            endcase
            send_item(rnd_coord(), ($urandom_range(1)) ? rnd_coord() :
                      CW'($urandom_range(184320) - 92160), f, 0, e,
                      !(n >= 400 && n < 600));
        end
        start <= 1'b0;

        drain = 0;
        while (pending_q.size() != 0 && drain < 10 * LATENCY + 100) begin
            @(posedge clk);
            drain++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        if (errors == 0 && pending_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_delay.sv
hw/rtl/rpc_sqrt.sv
hw/rtl/rpc_prep.sv
hw/rtl/rpc_cordic.sv
hw/rtl/rect_polar_converter.sv
dv/rect_polar_converter_tb.sv
